@@ rtl/fppd_pkg.sv @@
package fppd_pkg;

  localparam int CMD_W      = 2;
  localparam int TID_W      = 8;
  localparam int PIDX_W     = 16;
  localparam int KEY_W      = TID_W + PIDX_W;
  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 5;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRIM  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRIM   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WB_EN    = 2'd1;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MISS_RD,
    ST_MISS,
    ST_TRIM,
    ST_FL_RD,
    ST_FL_EMIT,
    ST_FL_EMPTY
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              page_present;
    logic [TID_W-1:0]  page_table;
    logic [PIDX_W-1:0] page_number;
    logic              write_back;
    logic [CNT_W-1:0]  dropped_count;
    logic [CNT_W-1:0]  resident_count;
    logic [ACC_W-1:0]  access_count;
    logic              last;
  } result_t;

endpackage

@@ rtl/fifo_page_pool_directory_unit.sv @@
// Directory of a page buffer pool with first-in-first-out replacement.
// Input words carry a command (get, trim, flush) and a page key made of a
// table id and a page number. Result words leave through a registered
// output stage; both channels use valid and stall. Configuration words
// (capacity, write-back enable) are taken at any cycle and are meant to be
// written while the block is idle.
// One command is worked on at a time; in_stall is high from the cycle after
// acceptance until the last result word has been loaded into the output stage,
// so the next command can be taken in the cycle that follows.
// A get scans the resident keys oldest first, one key per cycle through the
// single read port of the key memory. A hit answers once the matching key
// has been compared; a miss, also taken at once when the pool is empty, reads
// the oldest key and then writes the new key and answers. A trim answers
// without reading the key memory. A flush reads one key per cycle while the
// receiver does not stall and sends one word per resident page, oldest first, or a single word when the pool is empty.
// While the receiver stalls, the output stage holds its word and the work
// waits on it. Reset empties the pool, clears the access count and sets the
// capacity to 16 with write-back disabled; the key memory is not cleared,
// since only keys of resident pages are ever used.
module fifo_page_pool_directory_unit #(
  parameter int POOL_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fppd_pkg::CMD_W-1:0]        in_cmd,
  input  logic [fppd_pkg::TID_W-1:0]        in_table_id,
  input  logic [fppd_pkg::PIDX_W-1:0]       in_page_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fppd_pkg::KIND_W-1:0]       out_kind,
  output logic                              out_hit,
  output logic [fppd_pkg::SLOT_W-1:0]       out_slot,
  output logic                              out_page_present,
  output logic [fppd_pkg::TID_W-1:0]        out_page_table,
  output logic [fppd_pkg::PIDX_W-1:0]       out_page_number,
  output logic                              out_write_back,
  output logic [fppd_pkg::CNT_W-1:0]        out_dropped_count,
  output logic [fppd_pkg::CNT_W-1:0]        out_resident_count,
  output logic [fppd_pkg::ACC_W-1:0]        out_access_count,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fppd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fppd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import fppd_pkg::*;

  localparam int PTR_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int SUM_W      = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int SLOT_EXT_W = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(POOL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_out(input logic [PTR_W-1:0] p);
    logic [SLOT_EXT_W-1:0] e;
    e = SLOT_EXT_W'(p);
    return e[SLOT_W-1:0];
  endfunction

  logic [KEY_W-1:0] mem [POOL_DEPTH];

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   oldest_r, oldest_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   cap_r;
  logic               wb_en_r;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               cmp_last_r, cmp_last_nxt;
  logic [PTR_W-1:0]   cmp_slot_r, cmp_slot_nxt;
  logic [KEY_W-1:0]   rdata_r;
  logic               out_valid_r;
  result_t            out_res_r;

  result_t            res_nxt;
  logic               emit;
  logic               mem_we;
  logic [PTR_W-1:0]   rd_addr;
  logic               in_acc;
  logic               out_free;
  logic [CNT_W-1:0]   cap_eff;
  logic [PTR_W-1:0]   ptr_next;
  logic               key_match;
  logic               scan_done;
  logic               evict;
  logic [PTR_W-1:0]   new_oldest;
  logic [CNT_W-1:0]   occ_keep;
  logic [SUM_W-1:0]   ins_sum;
  logic [PTR_W-1:0]   ins_slot;
  logic [CNT_W-1:0]   drop;
  logic [SUM_W-1:0]   trim_sum;
  logic [PTR_W-1:0]   trim_oldest;
  logic               fl_last;
  logic [ACC_W-1:0]   acc_inc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign cap_eff = (cap_r == '0) ? CNT_W'(1) :
                   ((SUM_W'(cap_r) > SUM_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : cap_r);

  assign ptr_next  = ptr_inc(ptr_r);
  assign key_match = cmp_vld_r && (rdata_r == key_r);
  assign scan_done = cmp_vld_r && cmp_last_r;

  assign evict       = (occ_r >= cap_eff) && (occ_r != '0);
  assign new_oldest  = evict ? ptr_inc(oldest_r) : oldest_r;
  assign occ_keep    = evict ? occ_r - CNT_W'(1) : occ_r;
  assign ins_sum     = SUM_W'(new_oldest) + SUM_W'(occ_keep);
  assign ins_slot    = (ins_sum >= SUM_W'(POOL_DEPTH)) ?
                       PTR_W'(ins_sum - SUM_W'(POOL_DEPTH)) : PTR_W'(ins_sum);

  assign drop        = (occ_r > cap_eff) ? occ_r - cap_eff : '0;
  assign trim_sum    = SUM_W'(oldest_r) + SUM_W'(drop);
  assign trim_oldest = (trim_sum >= SUM_W'(POOL_DEPTH)) ?
                       PTR_W'(trim_sum - SUM_W'(POOL_DEPTH)) : PTR_W'(trim_sum);

  assign fl_last = ((iss_r + CNT_W'(1)) == occ_r);
  assign acc_inc = (acc_r == '1) ? acc_r : acc_r + ACC_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_GET:   state_nxt = (occ_r == '0) ? ST_MISS_RD : ST_SCAN;
            CMD_TRIM:  state_nxt = ST_TRIM;
            CMD_FLUSH: state_nxt = (occ_r == '0) ? ST_FL_EMPTY : ST_FL_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (key_match) begin
          if (out_free) state_nxt = ST_IDLE;
        end else if (scan_done) begin
          state_nxt = ST_MISS_RD;
        end
      end
      ST_MISS_RD:  state_nxt = ST_MISS;
      ST_MISS:     if (out_free) state_nxt = ST_IDLE;
      ST_TRIM:     if (out_free) state_nxt = ST_IDLE;
      ST_FL_EMPTY: if (out_free) state_nxt = ST_IDLE;
      ST_FL_RD:    state_nxt = ST_FL_EMIT;
      ST_FL_EMIT:  if (out_free && fl_last) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    oldest_nxt   = oldest_r;
    occ_nxt      = occ_r;
    acc_nxt      = acc_r;
    key_nxt      = key_r;
    ptr_nxt      = ptr_r;
    iss_nxt      = iss_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_last_nxt = cmp_last_r;
    cmp_slot_nxt = cmp_slot_r;
    rd_addr      = ptr_r;
    mem_we       = 1'b0;
    emit         = 1'b0;
    res_nxt      = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt     = {in_table_id, in_page_index};
          ptr_nxt     = oldest_r;
          iss_nxt     = '0;
          cmp_vld_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (key_match) begin
          rd_addr = cmp_slot_r;
          if (out_free) begin
            emit                   = 1'b1;
            res_nxt.kind           = KIND_LOOKUP;
            res_nxt.hit            = 1'b1;
            res_nxt.slot           = slot_out(cmp_slot_r);
            res_nxt.resident_count = occ_r;
            res_nxt.access_count   = acc_r;
            res_nxt.last           = 1'b1;
          end
        end else if (!scan_done) begin
          rd_addr      = ptr_r;
          cmp_vld_nxt  = 1'b1;
          cmp_slot_nxt = ptr_r;
          cmp_last_nxt = ((iss_r + CNT_W'(1)) == occ_r);
          ptr_nxt      = ptr_next;
          iss_nxt      = iss_r + CNT_W'(1);
        end
      end
      ST_MISS_RD: begin
        rd_addr = oldest_r;
      end
      ST_MISS: begin
        rd_addr = oldest_r;
        if (out_free) begin
          mem_we                 = 1'b1;
          oldest_nxt             = new_oldest;
          occ_nxt                = occ_keep + CNT_W'(1);
          acc_nxt                = acc_inc;
          emit                   = 1'b1;
          res_nxt.kind           = KIND_LOOKUP;
          res_nxt.slot           = slot_out(ins_slot);
          res_nxt.page_present   = evict;
          res_nxt.page_table     = evict ? rdata_r[KEY_W-1:PIDX_W] : '0;
          res_nxt.page_number    = evict ? rdata_r[PIDX_W-1:0] : '0;
          res_nxt.write_back     = evict && wb_en_r;
          res_nxt.resident_count = occ_keep + CNT_W'(1);
          res_nxt.access_count   = acc_inc;
          res_nxt.last           = 1'b1;
        end
      end
      ST_TRIM: begin
        if (out_free) begin
          oldest_nxt             = trim_oldest;
          occ_nxt                = occ_r - drop;
          emit                   = 1'b1;
          res_nxt.kind           = KIND_TRIM;
          res_nxt.dropped_count  = drop;
          res_nxt.resident_count = occ_r - drop;
          res_nxt.access_count   = acc_r;
          res_nxt.last           = 1'b1;
        end
      end
      ST_FL_EMPTY: begin
        if (out_free) begin
          emit                 = 1'b1;
          res_nxt.kind         = KIND_FLUSH;
          res_nxt.access_count = acc_r;
          res_nxt.last         = 1'b1;
        end
      end
      ST_FL_RD: begin
        rd_addr = ptr_r;
      end
      ST_FL_EMIT: begin
        rd_addr = out_free ? ptr_next : ptr_r;
        if (out_free) begin
          acc_nxt                = acc_inc;
          ptr_nxt                = ptr_next;
          iss_nxt                = iss_r + CNT_W'(1);
          emit                   = 1'b1;
          res_nxt.kind           = KIND_FLUSH;
          res_nxt.page_present   = 1'b1;
          res_nxt.page_table     = rdata_r[KEY_W-1:PIDX_W];
          res_nxt.page_number    = rdata_r[PIDX_W-1:0];
          res_nxt.write_back     = 1'b1;
          res_nxt.resident_count = occ_r;
          res_nxt.access_count   = acc_inc;
          res_nxt.last           = fl_last;
        end
      end
      default: begin
        rd_addr = ptr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ins_slot] <= key_r;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      occ_r       <= '0;
      acc_r       <= '0;
      cap_r       <= CAP_RESET;
      wb_en_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      oldest_r  <= oldest_nxt;
      occ_r     <= occ_nxt;
      acc_r     <= acc_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAPACITY: cap_r   <= cfg_data;
          CFG_WB_EN:    wb_en_r <= cfg_data[0];
          default:      ;
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    ptr_r      <= ptr_nxt;
    iss_r      <= iss_nxt;
    cmp_last_r <= cmp_last_nxt;
    cmp_slot_r <= cmp_slot_nxt;
    if (emit) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_res_r.kind;
  assign out_hit            = out_res_r.hit;
  assign out_slot           = out_res_r.slot;
  assign out_page_present   = out_res_r.page_present;
  assign out_page_table     = out_res_r.page_table;
  assign out_page_number    = out_res_r.page_number;
  assign out_write_back     = out_res_r.write_back;
  assign out_dropped_count  = out_res_r.dropped_count;
  assign out_resident_count = out_res_r.resident_count;
  assign out_access_count   = out_res_r.access_count;
  assign out_last           = out_res_r.last;

endmodule
